### design/control_packet_validator_macros.svh
// ----------------------------------------------------------------------------
// Control packet validator assertion macros
// Shared concurrent assertion forms for the validator RTL.
// ----------------------------------------------------------------------------
`ifndef CONTROL_PACKET_VALIDATOR_MACROS_SVH
`define CONTROL_PACKET_VALIDATOR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CPV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("control_packet_validator: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define CPV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("control_packet_validator: next-cycle check failed");

`endif

### design/cpv_pkg.sv
// ----------------------------------------------------------------------------
// cpv_pkg
// Types, constants and the CRC-32 byte step for the control packet validator.
// ----------------------------------------------------------------------------
package cpv_pkg;

    localparam int POS_W       = 6;
    localparam int CMD_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [POS_W-1:0] PACKET_BYTES = 6'd40;
    localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
    localparam logic [POS_W-1:0] POS_VERSION0 = 6'd4;
    localparam logic [POS_W-1:0] POS_VERSION1 = 6'd5;
    localparam logic [POS_W-1:0] POS_CMD_LO   = 6'd6;
    localparam logic [POS_W-1:0] POS_CMD_HI   = 6'd7;
    localparam logic [POS_W-1:0] POS_SIZE_LO  = 6'd8;
    localparam logic [POS_W-1:0] POS_CRC      = 6'd12;
    localparam logic [POS_W-1:0] POS_SEQ      = 6'd16;
    localparam logic [POS_W-1:0] POS_TS       = 6'd24;
    localparam logic [POS_W-1:0] POS_RESV     = 6'd32;

    // "SVTC" in arrival order, byte 0 in the low lane
    localparam logic [31:0] MAGIC_WORD    = 32'h4354_5653;
    localparam logic [7:0]  VERSION_LO    = 8'd1;
    localparam logic [7:0]  DECLARED_SIZE = 8'd40;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_MAX = 1'b1;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_SIZE      = 4'd1;
    localparam logic [3:0] ERR_MAGIC     = 4'd2;
    localparam logic [3:0] ERR_VERSION   = 4'd3;
    localparam logic [3:0] ERR_COMMAND   = 4'd4;
    localparam logic [3:0] ERR_DECLARED  = 4'd5;
    localparam logic [3:0] ERR_CRC       = 4'd6;
    localparam logic [3:0] ERR_RESERVED  = 4'd7;
    localparam logic [3:0] ERR_TIMESTAMP = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         error_code;
        logic [CMD_W-1:0]   command_code;
        logic [63:0]        sequence_number;
        logic signed [63:0] timestamp_ns;
    } out_item_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/cpv_packet_check.sv
// ----------------------------------------------------------------------------
// cpv_packet_check
// Per-packet state: byte count, header checks, field capture and running CRC.
// Gives the result for the current byte as if it were the last one.
// ----------------------------------------------------------------------------
module cpv_packet_check (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  cpv_pkg::in_item_t                    item,
    input  logic [cpv_pkg::CMD_W-1:0]            command_min,
    input  logic [cpv_pkg::CMD_W-1:0]            command_max,
    output cpv_pkg::out_item_t                   result
);
    import cpv_pkg::*;

    logic [POS_W-1:0] pos_reg,      pos_next,      pos_upd;
    logic [2:0]       hdr_err_reg,  hdr_err_next,  hdr_err_upd;
    logic [31:0]      rx_crc_reg,   rx_crc_next,   rx_crc_upd;
    logic [31:0]      crc_reg,      crc_next,      crc_upd;
    logic [CMD_W-1:0] cmd_reg,      cmd_next,      cmd_upd;
    logic [63:0]      seq_reg,      seq_next,      seq_upd;
    logic [63:0]      ts_reg,       ts_next,       ts_upd;
    logic             resv_reg,     resv_next,     resv_upd;

    logic [7:0]       b;
    logic [CMD_W-1:0] cmd_full;
    logic [2:0]       flag_code;
    logic             flag_hit;
    logic [3:0]       code;

    assign b        = item.data_byte;
    assign cmd_full = {b, cmd_reg[7:0]};

    always_comb
    begin
        pos_upd     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        rx_crc_upd  = rx_crc_reg;
        crc_upd     = crc_reg;
        cmd_upd     = cmd_reg;
        seq_upd     = seq_reg;
        ts_upd      = ts_reg;
        resv_upd    = resv_reg;
        flag_hit    = 1'b0;
        flag_code   = ERR_NONE[2:0];

        priority if (pos_reg < POS_VERSION0)
        begin
            flag_hit  = (b != MAGIC_WORD[{pos_reg[1:0], 3'b000} +: 8]);
            flag_code = ERR_MAGIC[2:0];
        end
        else if (pos_reg == POS_VERSION0)
        begin
            flag_hit  = (b != VERSION_LO);
            flag_code = ERR_VERSION[2:0];
        end
        else if (pos_reg == POS_VERSION1)
        begin
            flag_hit  = (b != 8'd0);
            flag_code = ERR_VERSION[2:0];
        end
        else if (pos_reg == POS_CMD_LO)
        begin
            cmd_upd = {8'd0, b};
        end
        else if (pos_reg == POS_CMD_HI)
        begin
            cmd_upd   = cmd_full;
            flag_hit  = (cmd_full < command_min) || (cmd_full > command_max);
            flag_code = ERR_COMMAND[2:0];
        end
        else if (pos_reg < POS_CRC)
        begin
            flag_hit  = (b != ((pos_reg == POS_SIZE_LO) ? DECLARED_SIZE : 8'd0));
            flag_code = ERR_DECLARED[2:0];
        end
        else if (pos_reg < POS_SEQ)
        begin
            rx_crc_upd[{pos_reg[1:0], 3'b000} +: 8] = b;
        end
        else if (pos_reg < PACKET_BYTES)
        begin
            crc_upd = crc32_byte(crc_reg, b);
            priority if (pos_reg < POS_TS)
            begin
                seq_upd[{pos_reg[2:0], 3'b000} +: 8] = b;
            end
            else if (pos_reg < POS_RESV)
            begin
                ts_upd[{pos_reg[2:0], 3'b000} +: 8] = b;
            end
            else
            begin
                resv_upd = resv_reg | (b != 8'd0);
            end
        end
        else
        begin
            flag_hit = 1'b0;
        end

        hdr_err_upd = (hdr_err_reg == ERR_NONE[2:0] && flag_hit) ? flag_code : hdr_err_reg;
    end

    always_comb
    begin
        priority if (pos_upd != PACKET_BYTES)
            code = ERR_SIZE;
        else if (hdr_err_upd != ERR_NONE[2:0])
            code = {1'b0, hdr_err_upd};
        else if (~crc_upd != rx_crc_upd)
            code = ERR_CRC;
        else if (resv_upd)
            code = ERR_RESERVED;
        else if (ts_upd == 64'd0 || ts_upd[63])
            code = ERR_TIMESTAMP;
        else
            code = ERR_NONE;

        result.error_code      = code;
        result.command_code    = (code == ERR_NONE) ? cmd_upd : '0;
        result.sequence_number = (code == ERR_NONE) ? seq_upd : '0;
        result.timestamp_ns    = (code == ERR_NONE) ? ts_upd  : '0;
    end

    always_comb
    begin
        pos_next     = pos_reg;
        hdr_err_next = hdr_err_reg;
        rx_crc_next  = rx_crc_reg;
        crc_next     = crc_reg;
        cmd_next     = cmd_reg;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        resv_next    = resv_reg;
        if (accept)
        begin
            if (item.last_byte)
            begin
                pos_next     = '0;
                hdr_err_next = '0;
                rx_crc_next  = '0;
                crc_next     = CRC_INIT;
                cmd_next     = '0;
                seq_next     = '0;
                ts_next      = '0;
                resv_next    = 1'b0;
            end
            else
            begin
                pos_next     = pos_upd;
                hdr_err_next = hdr_err_upd;
                rx_crc_next  = rx_crc_upd;
                crc_next     = crc_upd;
                cmd_next     = cmd_upd;
                seq_next     = seq_upd;
                ts_next      = ts_upd;
                resv_next    = resv_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_err_reg <= '0;
            rx_crc_reg  <= '0;
            crc_reg     <= CRC_INIT;
            cmd_reg     <= '0;
            seq_reg     <= '0;
            ts_reg      <= '0;
            resv_reg    <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            hdr_err_reg <= hdr_err_next;
            rx_crc_reg  <= rx_crc_next;
            crc_reg     <= crc_next;
            cmd_reg     <= cmd_next;
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            resv_reg    <= resv_next;
        end
    end

endmodule

### design/control_packet_validator.sv
// ----------------------------------------------------------------------------
// control_packet_validator
// Checks a 40-byte control packet streamed one byte per transaction and
// reports one result transaction on the marked last byte.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while the input is not stalled; the byte-wide CRC step
// and field checks sit between the byte input and the result register.
// Input stalls only while a result is held and the output is stalled.
// Reset clears packet state, output valid, and sets command range to 0..65535.
`include "control_packet_validator_macros.svh"

module control_packet_validator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  cpv_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output cpv_pkg::out_item_t                   out_data,
    input  logic                                 cfg_write,
    input  logic [cpv_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cpv_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import cpv_pkg::*;

    logic [CMD_W-1:0] cmd_min_reg, cmd_min_next;
    logic [CMD_W-1:0] cmd_max_reg, cmd_max_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        result;
    logic             accept;
    logic             finish;
    logic             out_error;
    logic             fields_zero;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign finish    = accept && in_data.last_byte;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cpv_packet_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (in_data),
        .command_min (cmd_min_reg),
        .command_max (cmd_max_reg),
        .result      (result)
    );

    always_comb
    begin
        cmd_min_next = cmd_min_reg;
        cmd_max_next = cmd_max_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COMMAND_MIN: cmd_min_next = cfg_data;
                REG_COMMAND_MAX: cmd_max_next = cfg_data;
                default:         cmd_min_next = cmd_min_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_min_reg   <= '0;
            cmd_max_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_min_reg   <= cmd_min_next;
            cmd_max_reg   <= cmd_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= result;
        end
    end

    assign out_error   = (out_data.error_code != ERR_NONE);
    assign fields_zero = (out_data.command_code == '0) && (out_data.sequence_number == '0)
                         && (out_data.timestamp_ns == '0);

    `CPV_ASSERT_NEXT(a_last_gives_result, clk, rst_n, finish, out_valid)
    `CPV_ASSERT_IMPLIES(a_no_overrun, clk, rst_n, out_valid && out_stall, !accept)
    `CPV_ASSERT_IMPLIES(a_code_range, clk, rst_n, out_valid, out_data.error_code <= ERR_TIMESTAMP)
    `CPV_ASSERT_IMPLIES(a_fields_zero_on_error, clk, rst_n, out_valid && out_error, fields_zero)

endmodule

### verif/control_packet_validator_checker.sv
// ----------------------------------------------------------------------------
// Control packet validator checker
// Watches the byte and result channels and the register port, keeps its own
// running view of the packet being received, and compares every result
// transaction field by field with the oldest verdict it has worked out.
// ----------------------------------------------------------------------------
package cpv_check_pkg;

    // Reflected CRC-32, one data bit at a time
    function automatic logic [31:0] crc32_shift_in(input logic [31:0] state,
                                                   input logic [7:0] octet);
        logic [31:0] s;
        s = state;
        for (int i = 0; i < 8; i++)
            s = (s >> 1) ^ (cpv_pkg::CRC_POLY & {32{s[0] ^ octet[i]}});
        return s;
    endfunction

endpackage

module control_packet_validator_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  cpv_pkg::in_item_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  cpv_pkg::out_item_t                  out_data,
    input  logic                                cfg_write,
    input  logic [cpv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cpv_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  failures,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cpv_pkg::*;
    import cpv_check_pkg::*;

    logic [CMD_W-1:0] cmd_lo;
    logic [CMD_W-1:0] cmd_hi;

    logic [POS_W-1:0] pos;
    logic [3:0]       hdr_err;
    logic [31:0]      crc_field;
    logic [31:0]      crc_acc;
    logic [CMD_W-1:0] cmd_acc;
    logic [63:0]      seq_acc;
    logic [63:0]      ts_acc;
    logic             resv_dirty;

    out_item_t pending_verdicts[$];
    int        fail_cnt;

    task automatic start_packet();
        pos        = '0;
        hdr_err    = ERR_NONE;
        crc_field  = '0;
        crc_acc    = CRC_INIT;
        cmd_acc    = '0;
        seq_acc    = '0;
        ts_acc     = '0;
        resv_dirty = 1'b0;
    endtask

    task automatic first_header_error(input logic [3:0] code);
        if (hdr_err == ERR_NONE)
            hdr_err = code;
    endtask

    task automatic absorb_byte(input in_item_t item);
        logic [7:0] b;
        out_item_t  verdict;
        b = item.data_byte;
        if (pos < POS_VERSION0)
        begin
            if (b != MAGIC_WORD[8*pos +: 8])
                first_header_error(ERR_MAGIC);
        end
        else if (pos == POS_VERSION0)
        begin
            if (b != VERSION_LO)
                first_header_error(ERR_VERSION);
        end
        else if (pos == POS_VERSION1)
        begin
            if (b != 8'd0)
                first_header_error(ERR_VERSION);
        end
        else if (pos == POS_CMD_LO)
            cmd_acc[7:0] = b;
        else if (pos == POS_CMD_HI)
        begin
            cmd_acc[15:8] = b;
            if (cmd_acc < cmd_lo || cmd_acc > cmd_hi)
                first_header_error(ERR_COMMAND);
        end
        else if (pos < POS_CRC)
        begin
            if (b != ((pos == POS_SIZE_LO) ? DECLARED_SIZE : 8'd0))
                first_header_error(ERR_DECLARED);
        end
        else if (pos < POS_SEQ)
            crc_field[8*(pos - POS_CRC) +: 8] = b;
        else if (pos < PACKET_BYTES)
        begin
            crc_acc = crc32_shift_in(crc_acc, b);
            if (pos < POS_TS)
                seq_acc[8*(pos - POS_SEQ) +: 8] = b;
            else if (pos < POS_RESV)
                ts_acc[8*(pos - POS_TS) +: 8] = b;
            else if (b != 8'd0)
                resv_dirty = 1'b1;
        end

        if (pos != POS_MAX)
            pos++;

        if (item.last_byte)
        begin
            verdict = '0;
            if (pos != PACKET_BYTES)
                verdict.error_code = ERR_SIZE;
            else if (hdr_err != ERR_NONE)
                verdict.error_code = hdr_err;
            else if (~crc_acc != crc_field)
                verdict.error_code = ERR_CRC;
            else if (resv_dirty)
                verdict.error_code = ERR_RESERVED;
            else if (ts_acc == 64'd0 || ts_acc[63])
                verdict.error_code = ERR_TIMESTAMP;
            else
            begin
                verdict.error_code      = ERR_NONE;
                verdict.command_code    = cmd_acc;
                verdict.sequence_number = seq_acc;
                verdict.timestamp_ns    = ts_acc;
            end
            pending_verdicts.push_back(verdict);
            start_packet();
        end
    endtask

    task automatic check_verdict(input out_item_t got);
        out_item_t want;
        if (pending_verdicts.size() == 0)
        begin
            $display("%0t: result transaction with nothing expected, actual %h", $time, got);
            fail_cnt++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.error_code !== want.error_code)
        begin
            $display("%0t: error_code expected %0d actual %0d",
                     $time, want.error_code, got.error_code);
            fail_cnt++;
        end
        if (got.command_code !== want.command_code)
        begin
            $display("%0t: command_code expected %h actual %h",
                     $time, want.command_code, got.command_code);
            fail_cnt++;
        end
        if (got.sequence_number !== want.sequence_number)
        begin
            $display("%0t: sequence_number expected %h actual %h",
                     $time, want.sequence_number, got.sequence_number);
            fail_cnt++;
        end
        if (got.timestamp_ns !== want.timestamp_ns)
        begin
            $display("%0t: timestamp_ns expected %h actual %h",
                     $time, want.timestamp_ns, got.timestamp_ns);
            fail_cnt++;
        end
    endtask

    // Byte handling uses the range as it stood before a write at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_lo = '0;
            cmd_hi = '1;
            start_packet();
            pending_verdicts.delete();
            fail_cnt = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_verdict(out_data);
            if (in_valid && !in_stall)
                absorb_byte(in_data);
            if (cfg_write)
            begin
                if (cfg_index == REG_COMMAND_MIN)
                    cmd_lo = cfg_data;
                else if (cfg_index == REG_COMMAND_MAX)
                    cmd_hi = cfg_data;
            end
            failures    <= fail_cnt;
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

### verif/control_packet_validator_test.sv
// ----------------------------------------------------------------------------
// Control packet validator testbench
// Streams directed and random control packets byte by byte, well-formed ones
// with random fields and injected faults as well as noise and wrong lengths,
// across several command ranges, with random gaps on the byte side and random
// stalls on the result side. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module control_packet_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpv_pkg::*;
    import cpv_check_pkg::*;

    localparam int SETTLE        = 4;
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_BYTES  = 1000;
    localparam int RANDOM_FRAMES = 24;
    localparam int FRAME_MAX     = 80;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     failures;
    int                     outstanding;

    logic [7:0]       frame [0:FRAME_MAX-1];
    int               frame_len;
    logic [CMD_W-1:0] rng_lo = 16'h0000;
    logic [CMD_W-1:0] rng_hi = 16'hFFFF;
    int               bytes_sent  = 0;
    int               frames_sent = 0;
    int               idle_cycles = 0;
    int               stall_left  = 0;

    control_packet_validator u_top (.*);

    control_packet_validator_checker u_chk (.*);

    always #1 clk = ~clk;

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!out_stall && $urandom_range(0, 99) < 45)
        begin
            out_stall <= 1'b1;
            stall_left = pause_len() - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 10);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL control_packet_validator");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] value, input logic tail);
        in_valid            <= 1'b1;
        in_data.data_byte   <= value;
        in_data.last_byte   <= tail;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        bit dense;
        dense = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < frame_len; i++)
        begin
            push_byte(frame[i], i == frame_len - 1);
            if (!dense && $urandom_range(0, 99) < 35)
            begin
                in_valid <= 1'b0;
                repeat (pause_len()) @(posedge clk);
            end
        end
        frames_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_range(input logic [CMD_W-1:0] lo, input logic [CMD_W-1:0] hi);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_COMMAND_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_COMMAND_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        rng_lo = lo;
        rng_hi = hi;
    endtask

    task automatic make_frame(input logic [CMD_W-1:0] cmd, input logic [63:0] seq,
                              input logic [63:0] ts, input logic [63:0] resv);
        logic [31:0] crc;
        for (int i = 0; i < 4; i++)
            frame[i] = MAGIC_WORD[8*i +: 8];
        frame[POS_VERSION0] = VERSION_LO;
        frame[POS_VERSION1] = 8'd0;
        frame[POS_CMD_LO]   = cmd[7:0];
        frame[POS_CMD_HI]   = cmd[15:8];
        frame[POS_SIZE_LO]  = DECLARED_SIZE;
        for (int i = POS_SIZE_LO + 1; i < POS_CRC; i++)
            frame[i] = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            frame[POS_SEQ + i]  = seq[8*i +: 8];
            frame[POS_TS + i]   = ts[8*i +: 8];
            frame[POS_RESV + i] = resv[8*i +: 8];
        end
        crc = CRC_INIT;
        for (int i = POS_SEQ; i < PACKET_BYTES; i++)
            crc = crc32_shift_in(crc, frame[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++)
            frame[POS_CRC + i] = crc[8*i +: 8];
        frame_len = PACKET_BYTES;
    endtask

    task automatic stretch_frame(input int len);
        for (int i = frame_len; i < len; i++)
            frame[i] = 8'($urandom);
        frame_len = len;
    endtask

    task automatic random_frame();
        logic [CMD_W-1:0] cmd;
        logic [63:0]      ts;
        logic [63:0]      resv;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            frame_len = 0;
            stretch_frame(($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 72));
            return;
        end

        r = $urandom_range(0, 99);
        if (rng_lo <= rng_hi && r < 75)
            cmd = 16'($urandom_range(rng_lo, rng_hi));
        else if (r < 85)
            cmd = $urandom_range(0, 1) ? rng_lo - 16'd1 : rng_hi + 16'd1;
        else if (r < 90)
            cmd = $urandom_range(0, 1) ? rng_lo : rng_hi;
        else
            cmd = 16'($urandom);

        ts = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 8)
            ts = '0;
        else if (r < 16)
            ts[63] = 1'b1;
        else
        begin
            ts[63] = 1'b0;
            if (ts == 64'd0)
                ts = 64'd1;
        end

        resv = '0;
        if ($urandom_range(0, 99) < 12)
        begin
            resv = {$urandom, $urandom};
            if (resv == 64'd0)
                resv = 64'd1;
        end

        make_frame(cmd, {$urandom, $urandom}, ts, resv);

        if ($urandom_range(0, 99) < 5)
            frame[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 5)
            frame[$urandom_range(4, 5)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 5)
            frame[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 5)
            frame[$urandom_range(12, 15)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 5)
            frame[$urandom_range(16, 39)] ^= 8'($urandom_range(1, 255));

        r = $urandom_range(0, 99);
        if (r < 7)
            frame_len = $urandom_range(1, 39);
        else if (r < 12)
            stretch_frame($urandom_range(41, 72));
    endtask

    initial
    begin
        logic [CMD_W-1:0] lim_a;
        logic [CMD_W-1:0] lim_b;
        int               phase;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range, field extremes
        make_frame(16'h0000, 64'h0, 64'h1, 64'h0);
        send_frame();
        make_frame(16'hFFFF, '1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
        send_frame();
        make_frame(16'h1234, 64'h0011_2233_4455_6677, 64'h0, 64'h0);
        send_frame();
        make_frame(16'h1234, 64'h8899_AABB_CCDD_EEFF, 64'h8000_0000_0000_0000, 64'h0);
        send_frame();
        make_frame(16'h00A5, 64'h5A5A_5A5A_A5A5_A5A5, 64'h0000_0123_4567_89AB,
                   64'h8000_0000_0000_0000);
        send_frame();
        make_frame(16'h00A5, 64'h1, 64'h0000_0123_4567_89AB, 64'h0);
        frame[POS_CRC + 1] ^= 8'hFF;
        send_frame();
        make_frame(16'h00A5, 64'h2, 64'h5, 64'h0);
        frame[POS_SIZE_LO] = 8'd41;
        send_frame();
        make_frame(16'h00A5, 64'h3, 64'h5, 64'h0);
        frame[POS_VERSION0] = 8'd2;
        send_frame();
        make_frame(16'h00A5, 64'h4, 64'h5, 64'h0);
        frame[POS_VERSION1] = 8'd1;
        send_frame();
        make_frame(16'h00A5, 64'h5, 64'h5, 64'h0);
        frame[0] = 8'h00;
        send_frame();
        // magic, version, declared size, CRC, reserved and timestamp faults at once: the magic check wins
        make_frame(16'h00A5, 64'h6, 64'h0, 64'hFF);
        frame[3] ^= 8'h01;
        frame[POS_VERSION0] = 8'd0;
        frame[POS_SIZE_LO + 1] = 8'd1;
        frame[POS_CRC + 2] ^= 8'h01;
        send_frame();

        // wrong lengths override every other check
        make_frame(16'h00A5, 64'h7, 64'h5, 64'h0);
        frame_len = 1;
        send_frame();
        make_frame(16'h00A5, 64'h8, 64'h5, 64'h0);
        frame_len = 39;
        send_frame();
        make_frame(16'h00A5, 64'h9, 64'h5, 64'h0);
        stretch_frame(41);
        send_frame();
        make_frame(16'h00A5, 64'hA, 64'h5, 64'h0);
        stretch_frame(72);
        send_frame();

        set_range(16'd5, 16'd5);
        make_frame(16'd5, 64'hB, 64'h5, 64'h0);
        send_frame();
        make_frame(16'd4, 64'hC, 64'h5, 64'h0);
        send_frame();
        make_frame(16'd6, 64'hD, 64'h5, 64'h0);
        send_frame();

        // empty range rejects everything
        set_range(16'h0010, 16'h0003);
        make_frame(16'd5, 64'hE, 64'h5, 64'h0);
        send_frame();
        make_frame(16'h0010, 64'hF, 64'h5, 64'h0);
        send_frame();

        bytes_sent  = 0;
        frames_sent = 0;
        phase       = 0;
        while (bytes_sent < RANDOM_BYTES || frames_sent < RANDOM_FRAMES)
        begin
            case (phase % 7)
                0: set_range(16'h0000, 16'hFFFF);
                1: set_range(16'h0000, 16'h0000);
                2: set_range(16'hFFFF, 16'hFFFF);
                3:
                begin
                    lim_a = 16'($urandom);
                    lim_b = 16'($urandom);
                    if (lim_a <= lim_b)
                        set_range(lim_a, lim_b);
                    else
                        set_range(lim_b, lim_a);
                end
                4:
                begin
                    lim_a = 16'($urandom_range(1, 65535));
                    set_range(lim_a, 16'($urandom_range(0, lim_a - 16'd1)));
                end
                5:
                begin
                    lim_a = 16'($urandom_range(0, 65000));
                    set_range(lim_a, lim_a + 16'($urandom_range(0, 15)));
                end
                default: set_range(16'($urandom_range(0, 255)),
                                   16'($urandom_range(65280, 65535)));
            endcase
            repeat (4)
            begin
                random_frame();
                send_frame();
            end
            phase++;
        end

        drain();
        if (failures == 0 && outstanding == 0)
            $display("PASS control_packet_validator");
        else
            $display("FAIL control_packet_validator");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/cpv_pkg.sv
design/cpv_packet_check.sv
design/control_packet_validator.sv
verif/control_packet_validator_checker.sv
verif/control_packet_validator_test.sv
